// ===== hdl/dns_fixed_answer_builder_core_defines.svh =====
// ---------------------------------------------------------------------------
// dns fixed answer builder assertion macros
// clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef DNS_FIXED_ANSWER_BUILDER_CORE_DEFINES_SVH
`define DNS_FIXED_ANSWER_BUILDER_CORE_DEFINES_SVH

// same-cycle implication
`define DFAB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DFAB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dfab_pkg.sv =====
// ---------------------------------------------------------------------------
// dfab_pkg
// shared types and constants of the dns fixed answer builder
// ---------------------------------------------------------------------------
package dfab_pkg;

  localparam int unsigned MAX_PACKET = 512;
  localparam int unsigned HDR_LEN    = 12;
  localparam int unsigned CMD_DEPTH  = 4;
  localparam int unsigned CMD_PTR_W  = $clog2(CMD_DEPTH);

  localparam logic [31:0] SPOOF_RESET = 32'hC0A8_0401;

  // command kinds
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_DISC = 2'd1;
  localparam logic [1:0] CMD_HDR  = 2'd2;
  localparam logic [1:0] CMD_TAIL = 2'd3;

  // last word index of each expanded command
  localparam logic [4:0] HDR_LAST_IDX  = 5'd11;
  localparam logic [4:0] TAIL_LAST_IDX = 5'd16;

  // parse phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_NAME   = 2'd1;
  localparam logic [1:0] PH_TYPE   = 2'd2;
  localparam logic [1:0] PH_DROP   = 2'd3;

  typedef struct packed {
    logic [1:0]            kind;
    logic [HDR_LEN*8-1:0]  data;   // byte operand in data[7:0]
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== hdl/dfab_front.sv =====
// ---------------------------------------------------------------------------
// dfab_front
// query parser: tracks header, name labels and type/class, issues commands
// ---------------------------------------------------------------------------
module dfab_front
  import dfab_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  input  fifo_stat_t fifo_stat,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [9:0]  pos_r, pos_nxt;
  logic [10:0] nlp_r, nlp_nxt;
  logic [10:0] qend_r, qend_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  hdr_r [HDR_LEN];

  logic        accept;
  logic [9:0]  pos_inc;
  logic [10:0] pos_w;
  logic [1:0]  ph_mid;
  logic [10:0] qend_mid;
  logic [HDR_LEN*8-1:0] hdr_out;

  assign in_tready = !fifo_stat.full;
  assign accept    = in_tvalid && !fifo_stat.full;
  assign pos_inc   = (pos_r == 10'd1023) ? pos_r : pos_r + 10'd1;
  assign pos_w     = {1'b0, pos_r};

  always_comb begin
    for (int i = 0; i < HDR_LEN; i++) begin
      hdr_out[i*8 +: 8] = hdr_r[i];
    end
    hdr_out[11*8 +: 8] = in_tdata;
    hdr_out[2*8 +: 8]  = 8'h84;
    hdr_out[3*8 +: 8]  = 8'h00;
    hdr_out[6*8 +: 8]  = 8'h00;
    hdr_out[7*8 +: 8]  = 8'h01;
  end

  always_comb begin
    pos_nxt   = pos_r;
    nlp_nxt   = nlp_r;
    qend_nxt  = qend_r;
    phase_nxt = phase_r;
    ph_mid    = phase_r;
    qend_mid  = qend_r;
    push      = 1'b0;
    push_cmd  = '{kind: CMD_BYTE, data: {{(HDR_LEN*8-8){1'b0}}, in_tdata}};
    if (accept) begin
      case (phase_r)
        PH_HEADER: begin
          if (pos_r < 10'd11) begin
            pos_nxt = pos_inc;
          end else if (in_tlast) begin
            push          = 1'b1;
            push_cmd.kind = CMD_DISC;
          end else begin
            push          = 1'b1;
            push_cmd.kind = CMD_HDR;
            push_cmd.data = hdr_out;
            phase_nxt     = PH_NAME;
            pos_nxt       = pos_inc;
          end
        end
        PH_DROP: begin
          pos_nxt = pos_inc;
        end
        default: begin
          push = 1'b1;
          if (pos_w + 11'd17 > 11'(MAX_PACKET)) begin
            push_cmd.kind = CMD_DISC;
            phase_nxt     = PH_DROP;
            pos_nxt       = pos_inc;
          end else begin
            if (phase_r == PH_NAME && pos_w == nlp_r) begin
              if (in_tdata == 8'd0) begin
                qend_mid = pos_w + 11'd5;
                ph_mid   = PH_TYPE;
              end else begin
                nlp_nxt = pos_w + {3'b0, in_tdata} + 11'd1;
              end
            end
            qend_nxt  = qend_mid;
            phase_nxt = ph_mid;
            if (ph_mid == PH_TYPE && pos_w + 11'd1 == qend_mid) begin
              push_cmd.kind = CMD_TAIL;
              phase_nxt     = PH_DROP;
              pos_nxt       = pos_inc;
            end else if (in_tlast) begin
              push_cmd.kind = CMD_DISC;
            end else begin
              pos_nxt = pos_inc;
            end
          end
        end
      endcase
      if (in_tlast) begin
        pos_nxt   = 10'd0;
        nlp_nxt   = 11'd12;
        qend_nxt  = 11'd0;
        phase_nxt = PH_HEADER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 10'd0;
      nlp_r   <= 11'd12;
      qend_r  <= 11'd0;
      phase_r <= PH_HEADER;
    end else begin
      pos_r   <= pos_nxt;
      nlp_r   <= nlp_nxt;
      qend_r  <= qend_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase_r == PH_HEADER && pos_r < 10'(HDR_LEN)) begin
      hdr_r[pos_r[3:0]] <= in_tdata;
    end
  end

endmodule

// ===== hdl/dfab_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// dfab_cmd_fifo
// short command queue between parser and emitter
// ---------------------------------------------------------------------------
module dfab_cmd_fifo
  import dfab_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_t       push_cmd,
  input  logic       pop,
  output cmd_t       head_cmd,
  output fifo_stat_t stat
);

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_r, rd_r;
  logic [CMD_PTR_W:0]   cnt_r;

  assign stat.full  = (cnt_r == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head_cmd   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (CMD_PTR_W+1)'(push) - (CMD_PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/dfab_back.sv =====
// ---------------------------------------------------------------------------
// dfab_back
// response emitter: expands commands into words behind an output register
// ---------------------------------------------------------------------------
module dfab_back
  import dfab_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        head_cmd,
  input  fifo_stat_t  fifo_stat,
  output logic        pop,
  input  logic [31:0] spoof_addr,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast,   // out_last
  output logic [0:0]  out_tuser    // [0] discard
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       disc_r;
  logic [4:0] idx_r, idx_nxt;

  logic       load;
  logic       end_cmd;
  logic [7:0] byte_w;
  logic       last_w;
  logic       disc_w;

  function automatic logic [7:0] tail_byte(input logic [4:0] idx, input logic [31:0] addr);
    logic [7:0] v;
    case (idx)
      5'd1:    v = 8'hC0;
      5'd2:    v = 8'h0C;
      5'd4:    v = 8'h01;
      5'd6:    v = 8'h01;
      5'd10:   v = 8'h3C;
      5'd12:   v = 8'h04;
      5'd13:   v = addr[31:24];
      5'd14:   v = addr[23:16];
      5'd15:   v = addr[15:8];
      5'd16:   v = addr[7:0];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  assign load = !fifo_stat.empty && (!valid_r || out_tready);

  always_comb begin
    byte_w  = head_cmd.data[7:0];
    last_w  = 1'b0;
    disc_w  = 1'b0;
    end_cmd = 1'b1;
    case (head_cmd.kind)
      CMD_HDR: begin
        byte_w  = head_cmd.data[idx_r[3:0]*8 +: 8];
        end_cmd = (idx_r == HDR_LAST_IDX);
      end
      CMD_TAIL: begin
        if (idx_r != 5'd0) begin
          byte_w = tail_byte(idx_r, spoof_addr);
        end
        end_cmd = (idx_r == TAIL_LAST_IDX);
        last_w  = end_cmd;
      end
      CMD_DISC: begin
        byte_w = 8'h00;
        last_w = 1'b1;
        disc_w = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign pop     = load && end_cmd;
  assign idx_nxt = !load ? idx_r : (end_cmd ? 5'd0 : idx_r + 5'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 5'd0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_w;
      last_r <= last_w;
      disc_r <= disc_w;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign out_tuser  = disc_r;

endmodule

// ===== hdl/dns_fixed_answer_builder_core.sv =====
// ---------------------------------------------------------------------------
// dns_fixed_answer_builder_core
// Takes a DNS query one byte per word and answers it with a fixed A record.
// The parser accepts one query byte per cycle while its four-entry command
// queue has room. The emitter sends one response byte per cycle while the
// output is ready: the twelfth header byte expands to the 12-byte rewritten
// header and the last type/class byte to itself plus the 16-byte answer. A
// well-formed query of n bytes whose question ends on its last byte gives
// n + 16 response words, so under sustained traffic with an output that
// never stalls the input is held back. A command passes the command queue
// and then the output register. Short queries give nothing; truncated or
// oversize questions end with one discard word (zero byte, tlast and tuser
// set). The answer address is the register at byte address 0 and may be
// changed only while no packet is in flight.
// ---------------------------------------------------------------------------
`include "dns_fixed_answer_builder_core_defines.svh"

module dns_fixed_answer_builder_core
  import dfab_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] in_byte
  input  logic        in_tlast,     // in_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] out_byte
  output logic        out_tlast,    // out_last
  output logic [0:0]  out_tuser,    // [0] discard
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] spoof_r;
  logic        push;
  logic        pop;
  cmd_t        push_cmd;
  cmd_t        head_cmd;
  fifo_stat_t  fifo_stat;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? spoof_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spoof_r <= SPOOF_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == 1'b0) begin
      spoof_r <= cfg_pwdata;
    end
  end

  dfab_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  dfab_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (fifo_stat)
  );

  dfab_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .fifo_stat  (fifo_stat),
    .pop        (pop),
    .spoof_addr (spoof_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `DFAB_ASSERT_IMP(a_no_push_full, fifo_stat.full, !push, "command pushed into full queue")
  `DFAB_ASSERT_IMP(a_no_pop_empty, fifo_stat.empty, !pop, "command popped from empty queue")
  `DFAB_ASSERT_IMP(a_disc_word, out_tvalid && out_tuser[0], out_tlast && out_tdata == 8'h00, "bad discard word")
  `DFAB_ASSERT_NXT(a_empty_idle, fifo_stat.empty && !out_tvalid, !out_tvalid, "word emitted with no command")

endmodule

// ===== verif/dfab_checker.sv =====
// ---------------------------------------------------------------------------
// dfab_checker
// Watches the query, response and register ports of the dns fixed answer
// builder. Every accepted query word is run through a cycle-free model of
// the parser, which queues the response words it must cause; every accepted
// response word is compared with the oldest queued one. Register writes
// update the model's copy of the answer address and reads are checked
// against it.
// ---------------------------------------------------------------------------
module dfab_checker
  import dfab_pkg::*;
#(
  parameter logic [2:0] SPOOF_ADDR = 3'd0
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [7:0]        in_tdata,     // [7:0] in_byte
  input  logic              in_tlast,     // in_last
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [7:0]        out_tdata,    // [7:0] out_byte
  input  logic              out_tlast,    // out_last
  input  logic [0:0]        out_tuser,    // [0] discard
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic [31:0]       cfg_prdata,
  input  logic              cfg_pready,
  output int unsigned       mismatches,
  output int unsigned       pending
);

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
    logic       disc;
  } resp_t;

  // answer record ahead of the address: pointer, type, class, ttl, length
  localparam logic [95:0] ANSWER_HEAD = 96'hC00C_0001_0001_0000_003C_0004;

  resp_t       response_q[$];
  logic [31:0] answer_ip;
  logic [9:0]  byte_pos;
  logic [7:0]  hdr_copy [12];
  logic [10:0] next_label;
  logic [10:0] question_end;
  logic [1:0]  phase;
  int unsigned fail_cnt = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic void push_resp(logic [7:0] o, logic l, logic d);
    resp_t r;
    r.octet = o;
    r.last  = l;
    r.disc  = d;
    response_q.push_back(r);
  endfunction

  function automatic void restart_query();
    byte_pos     = '0;
    next_label   = 11'd12;
    question_end = '0;
    phase        = PH_HEADER;
  endfunction

  function automatic void next_pos();
    if (byte_pos != 10'd1023) begin
      byte_pos = byte_pos + 10'd1;
    end
  endfunction

  function automatic void predict_octet(logic [7:0] b, logic lst);
    int unsigned p;
    logic [7:0]  v;
    p = byte_pos;
    if (phase == PH_HEADER) begin
      if (p < HDR_LEN) begin
        hdr_copy[p] = b;
      end
      if (p < HDR_LEN - 1) begin
        if (lst) restart_query();
        else next_pos();
        return;
      end
      if (lst) begin
        push_resp(8'h00, 1'b1, 1'b1);
        restart_query();
        return;
      end
      // flags forced to 0x8400, answer count forced to 1
      for (int i = 0; i < HDR_LEN; i++) begin
        case (i)
          2: begin
            v = 8'h84;
          end
          3, 6: begin
            v = 8'h00;
          end
          7: begin
            v = 8'h01;
          end
          default: begin
            v = hdr_copy[i];
          end
        endcase
        push_resp(v, 1'b0, 1'b0);
      end
      phase = PH_NAME;
      next_pos();
      return;
    end
    if (phase == PH_DROP) begin
      if (lst) restart_query();
      else next_pos();
      return;
    end
    // response would outgrow the packet limit
    if (p + 17 > MAX_PACKET) begin
      push_resp(8'h00, 1'b1, 1'b1);
      if (lst) begin
        restart_query();
      end else begin
        phase = PH_DROP;
        next_pos();
      end
      return;
    end
    if (phase == PH_NAME && p == next_label) begin
      if (b == 8'h00) begin
        question_end = 11'(p + 5);
        phase        = PH_TYPE;
      end else begin
        next_label = 11'(p + b + 1);
      end
    end
    if (phase == PH_TYPE && p + 1 == question_end) begin
      push_resp(b, 1'b0, 1'b0);
      for (int i = 0; i < 12; i++) begin
        push_resp(ANSWER_HEAD[95 - 8*i -: 8], 1'b0, 1'b0);
      end
      push_resp(answer_ip[31:24], 1'b0, 1'b0);
      push_resp(answer_ip[23:16], 1'b0, 1'b0);
      push_resp(answer_ip[15:8],  1'b0, 1'b0);
      push_resp(answer_ip[7:0],   1'b1, 1'b0);
      if (lst) begin
        restart_query();
      end else begin
        phase = PH_DROP;
        next_pos();
      end
      return;
    end
    // question cut short
    if (lst) begin
      push_resp(8'h00, 1'b1, 1'b1);
      restart_query();
      return;
    end
    push_resp(b, 1'b0, 1'b0);
    next_pos();
  endfunction

  always @(posedge clk) begin
    resp_t want;
    if (!rst_n) begin
      response_q.delete();
      answer_ip = SPOOF_RESET;
      restart_query();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == SPOOF_ADDR) begin
        if (cfg_pwrite) begin
          answer_ip = cfg_pwdata;
        end else if (cfg_prdata !== answer_ip) begin
          $error("spoof_address: expected %08h, got %08h", answer_ip, cfg_prdata);
          fail_cnt++;
        end
      end
      if (in_tvalid && in_tready) begin
        predict_octet(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (response_q.size() == 0) begin
          $error("unexpected response word %02h last %0b discard %0b",
                 out_tdata, out_tlast, out_tuser[0]);
          fail_cnt++;
        end else begin
          want = response_q.pop_front();
          if (out_tdata !== want.octet) begin
            $error("out_byte: expected %02h, got %02h", want.octet, out_tdata);
            fail_cnt++;
          end
          if (out_tlast !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_tlast);
            fail_cnt++;
          end
          if (out_tuser[0] !== want.disc) begin
            $error("discard: expected %0b, got %0b", want.disc, out_tuser[0]);
            fail_cnt++;
          end
        end
      end
    end
    mismatches <= fail_cnt;
    pending    <= response_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives dns queries into the fixed answer builder: a few hand-built packets
// for the header, truncation, size-limit and long-label cases, then random
// well-formed queries mixed with short, cut and garbage packets. The answer
// address is rewritten between phases; source and sink back-pressure change
// twice. The checker predicts and compares every response word.
// ---------------------------------------------------------------------------
module testbench;
  import dfab_pkg::*;

  localparam logic [2:0] SPOOF_ADDR    = 3'd0;
  localparam int         SETTLE_CYCLES = 40;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;    // [7:0] in_byte
  logic        in_tlast    = 1'b0;  // in_last
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;           // [7:0] out_byte
  logic        out_tlast;           // out_last
  logic [0:0]  out_tuser;           // [0] discard
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int unsigned mismatches;
  int unsigned pending;

  logic [7:0]  query_q[$];
  int unsigned sent_words    = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;

  always #6 clk = ~clk;

  dns_fixed_answer_builder_core uut (.*);

  dfab_checker #(.SPOOF_ADDR(SPOOF_ADDR)) chk (.*);

  // sink back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  initial begin
    #4800000;
    $display("FAIL");
    $finish;
  end

  task automatic set_idling(int unsigned src, int unsigned sink);
    src_idle_pct  = src;
    sink_idle_pct = sink;
  endtask

  task automatic send_query();
    int unsigned n;
    n = query_q.size();
    for (int unsigned i = 0; i < n; i++) begin
      while ($urandom_range(0, 99) < src_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= query_q[i];
      in_tlast  <= (i == n - 1);
      do @(posedge clk); while (!in_tready);
      sent_words++;
    end
    query_q.delete();
  endtask

  function automatic void add_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      query_q.push_back(8'($urandom));
    end
  endfunction

  function automatic void add_fill(int unsigned n, logic [7:0] v);
    for (int unsigned i = 0; i < n; i++) begin
      query_q.push_back(v);
    end
  endfunction

  function automatic void add_name(int unsigned labels, int unsigned maxlen);
    int unsigned len;
    for (int unsigned i = 0; i < labels; i++) begin
      len = $urandom_range(1, maxlen);
      query_q.push_back(8'(len));
      add_random(len);
    end
    query_q.push_back(8'h00);
  endfunction

  function automatic void cut_query(int unsigned len);
    while (query_q.size() > len) begin
      void'(query_q.pop_back());
    end
  endfunction

  task automatic cfg_write(logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= SPOOF_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= SPOOF_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every response, then let words that cause none drain
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    // short packets, longest short packet ends on index 10
    add_random(1);
    send_query();
    add_random(11);
    send_query();
    // header only
    add_random(12);
    send_query();
    // root name, header all ones
    add_fill(12, 8'hFF);
    query_q.push_back(8'h00);
    add_fill(4, 8'hFF);
    send_query();
    // one label of 0xff, header all zeros, trailing words
    add_fill(12, 8'h00);
    query_q.push_back(8'h01);
    query_q.push_back(8'hFF);
    query_q.push_back(8'h00);
    add_fill(4, 8'hFF);
    add_random(3);
    send_query();
    // cut on the first type word
    add_random(12);
    add_name(2, 5);
    query_q.push_back(8'h00);
    send_query();
    // label length at or above 0xc0 is a plain length, cut inside the label
    add_random(12);
    query_q.push_back(8'hC0);
    add_random(5);
    send_query();
    // name runs past the size limit, then a few dropped words
    add_random(12);
    query_q.push_back(8'hFF);
    add_random(255);
    query_q.push_back(8'hFF);
    add_random(500 - query_q.size());
    send_query();
  endtask

  task automatic run_random(int unsigned words);
    int unsigned target;
    int unsigned pick;
    int unsigned qlen;
    target = sent_words + words;
    while (sent_words < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        add_random(12);
        add_name($urandom_range(1, 3), 12);
        add_random(4);
        if ($urandom_range(0, 9) < 3) begin
          add_random($urandom_range(1, 6));
        end
      end else if (pick < 70) begin
        add_random(12);
        add_name($urandom_range(1, 3), 10);
        add_random(4);
        qlen = query_q.size();
        cut_query($urandom_range(13, qlen - 1));
      end else if (pick < 77) begin
        add_random($urandom_range(1, 11));
      end else if (pick < 82) begin
        add_random(12);
      end else if (pick < 90) begin
        add_random(12 + $urandom_range(1, 30));
      end else if (pick < 93) begin
        add_random(12);
        query_q.push_back(8'($urandom_range(192, 255)));
        add_random($urandom_range(1, 8));
      end else begin
        add_random(12);
        add_name($urandom_range(4, 6), 30);
        add_random(4);
      end
      send_query();
    end
  endtask

  initial begin
    int unsigned wait_cnt;
    set_idling(15, 83);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_read();
    run_directed();

    settle();
    cfg_write(32'h0000_0000);
    cfg_read();
    run_random(40);

    settle();
    set_idling(83, 15);
    cfg_write(32'hFFFF_FFFF);
    cfg_read();
    run_random(40);

    settle();
    set_idling(0, 0);
    cfg_write($urandom);
    cfg_read();
    run_random(40);

    in_tvalid <= 1'b0;
    @(posedge clk);
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending != 0) begin
      $error("%0d response words never arrived", pending);
    end
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/dfab_pkg.sv
hdl/dfab_front.sv
hdl/dfab_cmd_fifo.sv
hdl/dfab_back.sv
hdl/dns_fixed_answer_builder_core.sv
verif/dfab_checker.sv
verif/testbench.sv
